// ===== rtl/lbcs_pkg.sv =====
// Package for the LED blink code sequencer: phase codes, register indexes,
// field widths and reset values. No dependencies.
package lbcs_pkg;

  // Field and register widths
  localparam int ERR_W      = 16;
  localparam int RAW_W      = ERR_W + 1;
  localparam int BEAT_W     = 10;
  localparam int TIMER_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default code width searched for the leading one
  localparam int CODE_BITS_DEF = 16;

  // A long symbol lasts this many beats
  localparam int LONG_BEATS = 3;

  // Register reset values
  localparam logic [BEAT_W-1:0] BEAT_RESET = 10'd200;
  localparam logic [ERR_W-1:0]  ERR_RESET  = 16'd0;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_TICKS = 1'd1;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HEAD       = 3'd1,
    PH_LEAD_LONG  = 3'd2,
    PH_LEAD_SHORT = 3'd3,
    PH_BIT_ON     = 3'd4,
    PH_SYM_OFF    = 3'd5,
    PH_TAIL       = 3'd6
  } phase_t;

endpackage

// ===== rtl/lbcs_ifs.sv =====
// Valid/ready channels of the LED blink code sequencer: tick requests in,
// LED results out. No dependencies.
interface lbcs_tick_if;
  logic valid;
  logic ready;
  logic tick;
  logic run;

  modport source (output valid, output tick, output run, input ready);
  modport sink   (input valid, input tick, input run, output ready);
endinterface

interface lbcs_led_if;
  logic valid;
  logic ready;
  logic led;
  logic pattern_end;

  modport source (output valid, output led, output pattern_end, input ready);
  modport sink   (input valid, input led, input pattern_end, output ready);
endinterface

// ===== rtl/led_blink_code_sequencer.sv =====
// LED blink code sequencer top level: phase state, beat timer, code latch
// and result register. Depends on lbcs_pkg and the channels in lbcs_ifs.
//
//   channel    dir   handshake          payload
//   tick_ch    in    valid/ready        tick, run
//   led_ch     out   valid/ready        led, pattern_end
//   cfg_*      in    cfg_we, no wait    cfg_addr, cfg_wdata
//
// One request per cycle: the phase, timer and code update is a single pass
// of logic from the state registers into the result register.
// A request is taken whenever the result register is empty or being read,
// so a stalled result holds off input only while the stall lasts.
// Synchronous reset rst: phase idle, counters zero, error_code 0,
// beat_ticks 200, no result pending. No clearing pass.
module led_blink_code_sequencer #(
  parameter int CODE_BITS = lbcs_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbcs_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [lbcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  lbcs_tick_if.sink                        tick_ch,
  lbcs_led_if.source                       led_ch
);

  localparam int WW    = CODE_BITS + 1;
  localparam int IDX_W = $clog2(WW);
  localparam int EXT_W = (WW > lbcs_pkg::RAW_W) ? WW : lbcs_pkg::RAW_W;

  // Configuration registers
  logic signed [lbcs_pkg::ERR_W-1:0] error_code;
  logic [lbcs_pkg::BEAT_W-1:0]       beat_ticks;

  // Sequencer state
  lbcs_pkg::phase_t             phase, phase_next;
  logic [lbcs_pkg::TIMER_W-1:0] phase_timer, phase_timer_next;
  logic [IDX_W-1:0]             bit_index, bit_index_next;
  logic [WW-1:0]                work_code, work_code_next;

  // Result register
  logic out_valid;
  logic out_led, out_led_next;
  logic out_end, out_end_next;

  logic in_acc;

  // Working signals
  lbcs_pkg::phase_t             cur_phase;
  logic [lbcs_pkg::TIMER_W-1:0] timer_base, timer_inc, beat1, beat3, len;
  logic [lbcs_pkg::BEAT_W-1:0]  beat;
  logic                         cur_bit;
  logic [lbcs_pkg::RAW_W-1:0]   raw_code;
  logic [EXT_W-1:0]             raw_ext;
  logic [WW-1:0]                work_latch;
  logic [IDX_W-1:0]             idx_latch;
  logic                         code_pos;

  // Input handshake: result register empty or draining
  assign tick_ch.ready = !out_valid || led_ch.ready;
  assign in_acc        = tick_ch.valid && tick_ch.ready;

  assign led_ch.valid       = out_valid;
  assign led_ch.led         = out_led;
  assign led_ch.pattern_end = out_end;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      error_code <= lbcs_pkg::ERR_RESET;
      beat_ticks <= lbcs_pkg::BEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lbcs_pkg::REG_ERROR_CODE: error_code <= cfg_wdata[lbcs_pkg::ERR_W-1:0];
        lbcs_pkg::REG_BEAT_TICKS: beat_ticks <= cfg_wdata[lbcs_pkg::BEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Code latch: sign fold and leading-one search
  always_comb begin
    code_pos = !error_code[lbcs_pkg::ERR_W-1] && (|error_code);
    if (code_pos) begin
      raw_code = {1'b0, error_code};
    end else if (error_code == '0) begin
      raw_code = '0;
    end else begin
      raw_code = lbcs_pkg::RAW_W'(1) - {error_code[lbcs_pkg::ERR_W-1], error_code};
    end
    raw_ext    = EXT_W'(raw_code);
    work_latch = raw_ext[WW-1:0];
    idx_latch  = '0;
    for (int i = 0; i < WW; i++) begin
      if (work_latch[i]) idx_latch = IDX_W'(i);
    end
  end

  // Phase length in ticks
  always_comb begin
    beat      = (beat_ticks == '0) ? lbcs_pkg::BEAT_W'(1) : beat_ticks;
    beat1     = lbcs_pkg::TIMER_W'(beat);
    beat3     = beat1 * lbcs_pkg::TIMER_W'(lbcs_pkg::LONG_BEATS);
    cur_phase = (phase == lbcs_pkg::PH_IDLE) ? lbcs_pkg::PH_HEAD : phase;
    cur_bit   = work_code[bit_index];
    if (cur_phase == lbcs_pkg::PH_LEAD_LONG ||
        (cur_phase == lbcs_pkg::PH_BIT_ON && cur_bit)) begin
      len = beat3;
    end else begin
      len = beat1;
    end
    timer_base = (phase == lbcs_pkg::PH_IDLE) ? '0 : phase_timer;
    timer_inc  = timer_base + lbcs_pkg::TIMER_W'(1);
  end

  // Next state and result
  always_comb begin
    phase_next       = cur_phase;
    phase_timer_next = timer_base;
    bit_index_next   = bit_index;
    work_code_next   = work_code;
    out_end_next     = 1'b0;
    if (!tick_ch.run) begin
      phase_next       = lbcs_pkg::PH_IDLE;
      phase_timer_next = '0;
      bit_index_next   = '0;
      work_code_next   = '0;
    end else if (tick_ch.tick) begin
      phase_timer_next = timer_inc;
      if (timer_inc >= len) begin
        phase_timer_next = '0;
        case (cur_phase)
          lbcs_pkg::PH_HEAD: begin
            work_code_next = work_latch;
            bit_index_next = idx_latch;
            phase_next     = code_pos ? lbcs_pkg::PH_LEAD_LONG
                                      : lbcs_pkg::PH_LEAD_SHORT;
          end
          lbcs_pkg::PH_LEAD_LONG,
          lbcs_pkg::PH_LEAD_SHORT,
          lbcs_pkg::PH_BIT_ON: begin
            phase_next = lbcs_pkg::PH_SYM_OFF;
          end
          lbcs_pkg::PH_SYM_OFF: begin
            if (bit_index != '0) begin
              bit_index_next = bit_index - IDX_W'(1);
              phase_next     = lbcs_pkg::PH_BIT_ON;
            end else begin
              phase_next = lbcs_pkg::PH_TAIL;
            end
          end
          lbcs_pkg::PH_TAIL: begin
            phase_next   = lbcs_pkg::PH_HEAD;
            out_end_next = 1'b1;
          end
          default: phase_next = lbcs_pkg::PH_HEAD;
        endcase
      end
    end
    out_led_next = (phase_next == lbcs_pkg::PH_LEAD_LONG ||
                    phase_next == lbcs_pkg::PH_LEAD_SHORT ||
                    phase_next == lbcs_pkg::PH_BIT_ON);
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lbcs_pkg::PH_IDLE;
      phase_timer <= '0;
      bit_index   <= '0;
      work_code   <= '0;
    end else if (in_acc) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      bit_index   <= bit_index_next;
      work_code   <= work_code_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (led_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_led <= out_led_next;
      out_end <= out_end_next;
    end
  end

endmodule

// ===== rtl/lbcs_checker.sv =====
// Port-level checks for the LED blink code sequencer, bound to the top level.
// Depends on led_blink_code_sequencer and its channels.
module lbcs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_run,
  input logic out_valid,
  input logic out_ready,
  input logic out_led,
  input logic out_end
);

  // Every request leaves a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("request accepted without a result");

  // Run low gives a dark, non-final result
  a_run_low_dark: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_run) |=> (!out_led && !out_end))
    else $error("LED or pattern end set while run was low");

  // The pattern ends in a gap, so the LED is off then
  a_end_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> !out_led)
    else $error("pattern end with LED on");

  // An empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_led) && $stable(out_end)))
    else $error("stalled result changed");

endmodule

bind led_blink_code_sequencer lbcs_checker u_lbcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tick_ch.valid),
  .in_ready  (tick_ch.ready),
  .in_run    (tick_ch.run),
  .out_valid (led_ch.valid),
  .out_ready (led_ch.ready),
  .out_led   (led_ch.led),
  .out_end   (led_ch.pattern_end)
);
